// ===== sv/bcfm_pkg.sv =====
// Shared types and constants of the battery cell frame monitor.
`default_nettype none
package bcfm_pkg;

  localparam int CELL_W     = 14;
  localparam int HIGH_W     = 13;
  localparam int SUM_W      = 17;
  localparam int CNT_W      = 5;
  localparam int TEMP_W     = 10;
  localparam int QIDX_W     = 4;
  localparam int GROUP_SIZE = 4;
  localparam int GSUM_W     = 15;
  localparam int GCNT_W     = 3;

  localparam logic [CELL_W-1:0] CELL_CEIL_MV = 14'd5000;
  localparam logic [CELL_W-1:0] LOW_NONE_MV  = 14'd10000;

  localparam logic [2:0] FRAME_STATUS    = 3'd0;
  localparam logic [2:0] FRAME_LAST_CELL = 3'd6;

  localparam logic KIND_CELL = 1'b0;
  localparam logic KIND_TEMP = 1'b1;

  localparam logic REG_IGNORE   = 1'b0;
  localparam logic REG_TEMP_OFS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MERGE
  } bcfm_state_t;

  typedef struct packed {
    logic              upd;
    logic              wr_ok;
    logic [2:0]        frame;
    logic [CELL_W-1:0] v0;
    logic [CELL_W-1:0] v1;
    logic [CELL_W-1:0] v2;
  } lane_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] lo_mv;
    logic              in_band;
    logic [HIGH_W-1:0] band_mv;
  } lane_term_t;

  typedef struct packed {
    logic [CELL_W-1:0] low_mv;
    logic [HIGH_W-1:0] high_mv;
    logic [SUM_W-1:0]  sum_mv;
    logic [CNT_W-1:0]  count;
  } stats_t;

endpackage
`default_nettype wire

// ===== sv/bcfm_lane.sv =====
// One cell lane: stores the cell value and its recorded extremes, and forms its statistics terms.
`default_nettype none
module bcfm_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bcfm_pkg::lane_req_t               req,
  input  logic [12:0]                       ignore_mv,
  output logic [bcfm_pkg::CELL_W-1:0]       cell_mv,
  output logic [bcfm_pkg::CELL_W-1:0]       lowest_mv,
  output logic [bcfm_pkg::CELL_W-1:0]       highest_mv,
  output bcfm_pkg::lane_term_t              term
);
  import bcfm_pkg::*;

  localparam logic [2:0] LANE_FRAME = 3'(LANE_IDX / 3 + 1);
  localparam int         LANE_SLOT  = LANE_IDX % 3;

  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic [CELL_W-1:0] lowest_r, lowest_nxt;
  logic [CELL_W-1:0] highest_r, highest_nxt;
  logic [CELL_W-1:0] slot_val;
  logic [CELL_W-1:0] ignore_ext;
  logic              wr;
  logic              above;

  assign ignore_ext = {1'b0, ignore_mv};
  assign wr         = req.upd && req.wr_ok && (req.frame == LANE_FRAME);

  always_comb begin
    case (LANE_SLOT)
      0:       slot_val = req.v0;
      1:       slot_val = req.v1;
      default: slot_val = req.v2;
    endcase
  end

  always_comb begin
    cell_nxt    = wr ? slot_val : cell_r;
    lowest_nxt  = lowest_r;
    highest_nxt = highest_r;
    if (req.upd && (lowest_r > cell_nxt) && (cell_nxt >= ignore_ext)) begin
      lowest_nxt = cell_nxt;
    end
    if (req.upd && (highest_r < cell_nxt) && (cell_nxt < CELL_CEIL_MV)) begin
      highest_nxt = cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r    <= '0;
      lowest_r  <= CELL_CEIL_MV;
      highest_r <= '0;
    end else begin
      cell_r    <= cell_nxt;
      lowest_r  <= lowest_nxt;
      highest_r <= highest_nxt;
    end
  end

  assign above        = cell_r > ignore_ext;
  assign term.lo_mv   = (above && (cell_r < LOW_NONE_MV)) ? cell_r : LOW_NONE_MV;
  assign term.in_band = above && (cell_r < CELL_CEIL_MV);
  assign term.band_mv = term.in_band ? cell_r[HIGH_W-1:0] : '0;

  assign cell_mv    = cell_r;
  assign lowest_mv  = lowest_r;
  assign highest_mv = highest_r;

endmodule
`default_nettype wire

// ===== sv/bcfm_merge.sv =====
// Merging stage: registered per-group reduction of the lane terms, then the final combine.
`default_nettype none
module bcfm_merge #(
  parameter int NUM_CELLS = 16
) (
  input  logic                  clk,
  input  logic                  load,
  input  bcfm_pkg::lane_term_t  terms [NUM_CELLS],
  output bcfm_pkg::stats_t      stats
);
  import bcfm_pkg::*;

  localparam int NUM_GROUPS = (NUM_CELLS + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [CELL_W-1:0] g_low_r  [NUM_GROUPS];
  logic [HIGH_W-1:0] g_high_r [NUM_GROUPS];
  logic [GSUM_W-1:0] g_sum_r  [NUM_GROUPS];
  logic [GCNT_W-1:0] g_cnt_r  [NUM_GROUPS];
  logic [CELL_W-1:0] g_low_nxt  [NUM_GROUPS];
  logic [HIGH_W-1:0] g_high_nxt [NUM_GROUPS];
  logic [GSUM_W-1:0] g_sum_nxt  [NUM_GROUPS];
  logic [GCNT_W-1:0] g_cnt_nxt  [NUM_GROUPS];

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      g_low_nxt[g]  = LOW_NONE_MV;
      g_high_nxt[g] = '0;
      g_sum_nxt[g]  = '0;
      g_cnt_nxt[g]  = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < NUM_CELLS) begin
          if (terms[g * GROUP_SIZE + k].lo_mv < g_low_nxt[g]) begin
            g_low_nxt[g] = terms[g * GROUP_SIZE + k].lo_mv;
          end
          if (terms[g * GROUP_SIZE + k].band_mv > g_high_nxt[g]) begin
            g_high_nxt[g] = terms[g * GROUP_SIZE + k].band_mv;
          end
          g_sum_nxt[g] = g_sum_nxt[g]
                         + GSUM_W'(terms[g * GROUP_SIZE + k].band_mv);
          g_cnt_nxt[g] = g_cnt_nxt[g]
                         + GCNT_W'(terms[g * GROUP_SIZE + k].in_band);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      g_low_r  <= g_low_nxt;
      g_high_r <= g_high_nxt;
      g_sum_r  <= g_sum_nxt;
      g_cnt_r  <= g_cnt_nxt;
    end
  end

  always_comb begin
    stats.low_mv  = LOW_NONE_MV;
    stats.high_mv = '0;
    stats.sum_mv  = '0;
    stats.count   = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (g_low_r[g] < stats.low_mv) begin
        stats.low_mv = g_low_r[g];
      end
      if (g_high_r[g] > stats.high_mv) begin
        stats.high_mv = g_high_r[g];
      end
      stats.sum_mv = stats.sum_mv + SUM_W'(g_sum_r[g]);
      stats.count  = stats.count + CNT_W'(g_cnt_r[g]);
    end
  end

endmodule
`default_nettype wire

// ===== sv/battery_cell_frame_monitor_top.sv =====
// Top level of the battery cell frame monitor: frame decode, cell lanes, merge and result register.
//
// Each request on the in_ channel is one module frame: a status frame, a cell
// frame, an empty frame or a temperature frame. It updates the stored words,
// cell values and sensor temperatures at the edge where it is taken, and
// exactly one result follows on the out_ channel. The result passes the
// registered group reduction of the cell lanes, then the final merge into the
// output register. No new request is taken while the group reduction loads,
// since its registers hold one request's terms at a time. The output register
// decouples the sides: while a result waits, the next request is still taken
// and reduced, and it then waits in the merge state until the result leaves.
// The user must write the ignore level and the temperature offset on the APB
// port only while the block is idle; the block does not enforce it. Reads
// return the stored values. Reset clears the cell values, recorded highest
// values, status words, temperatures and configuration registers, sets the
// recorded lowest values to the 5000 mV ceiling and empties the pipeline.
`default_nettype none
module battery_cell_frame_monitor_top #(
  parameter int NUM_CELLS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic [2:0]                         in_frame_index,
  input  logic [7:0]                         in_byte0,
  input  logic [7:0]                         in_byte1,
  input  logic [7:0]                         in_byte2,
  input  logic [7:0]                         in_byte3,
  input  logic [7:0]                         in_byte4,
  input  logic [7:0]                         in_byte5,
  input  logic                               in_ignition,
  input  logic [3:0]                         in_query_cell,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [13:0]                        out_low_cell_mv,
  output logic [12:0]                        out_high_cell_mv,
  output logic [16:0]                        out_sum_mv,
  output logic [4:0]                         out_valid_count,
  output logic [15:0]                        out_balance_status,
  output logic [31:0]                        out_error_word,
  output logic signed [9:0]                  out_low_temp_c,
  output logic signed [9:0]                  out_high_temp_c,
  output logic [13:0]                        out_query_mv,
  output logic [13:0]                        out_query_lowest_mv,
  output logic [13:0]                        out_query_highest_mv
);
  import bcfm_pkg::*;

  function automatic logic signed [TEMP_W-1:0] decode_temp(input logic [7:0] b,
                                                           input logic signed [7:0] ofs);
    logic signed [TEMP_W-1:0] t;
    t = $signed({2'b00, b}) - 10'sd40;
    if (b != 8'd0) begin
      t = t + {{(TEMP_W-8){ofs[7]}}, ofs};
    end
    return t;
  endfunction

  bcfm_state_t state_r, state_nxt;

  logic [12:0]              ignore_r;
  logic signed [7:0]        temp_ofs_r;
  logic [15:0]              balance_r;
  logic [31:0]              fault_r;
  logic signed [TEMP_W-1:0] sensor0_r, sensor1_r;
  logic [QIDX_W-1:0]        query_r;
  logic                     out_valid_r, out_valid_nxt;

  logic in_acc, out_free, part_load, out_load, cfg_wr;

  lane_req_t  req;
  lane_term_t terms      [NUM_CELLS];
  logic [CELL_W-1:0] lane_mv      [NUM_CELLS];
  logic [CELL_W-1:0] lane_lowest  [NUM_CELLS];
  logic [CELL_W-1:0] lane_highest [NUM_CELLS];
  stats_t     stats;

  logic [CELL_W-1:0]        q_mv, q_lowest, q_highest;
  logic signed [TEMP_W-1:0] t_low, t_high;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_r   <= '0;
      temp_ofs_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IGNORE:   ignore_r   <= pwdata[12:0];
        REG_TEMP_OFS: temp_ofs_r <= $signed(pwdata[7:0]);
        default:      ignore_r   <= ignore_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IGNORE:   prdata = {19'd0, ignore_r};
      REG_TEMP_OFS: prdata = {24'd0, temp_ofs_r};
      default:      prdata = '0;
    endcase
  end

  // Control.
  assign out_free = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    case (state_r)
      ST_IDLE:   state_nxt = in_acc ? ST_REDUCE : ST_IDLE;
      ST_REDUCE: state_nxt = ST_MERGE;
      ST_MERGE: begin
        if (out_free) begin
          state_nxt = in_acc ? ST_REDUCE : ST_IDLE;
        end else begin
          state_nxt = ST_MERGE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        part_load = 1'b0;
        out_load  = 1'b0;
      end
      ST_REDUCE: begin
        in_ready  = 1'b0;
        part_load = 1'b1;
        out_load  = 1'b0;
      end
      ST_MERGE: begin
        in_ready  = out_free;
        part_load = 1'b0;
        out_load  = out_free;
      end
      default: begin
        in_ready  = 1'b0;
        part_load = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Frame decode and stored words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      balance_r <= '0;
      fault_r   <= '0;
      sensor0_r <= '0;
      sensor1_r <= '0;
    end else if (in_acc) begin
      if (in_kind == KIND_TEMP) begin
        sensor0_r <= decode_temp(in_byte0, temp_ofs_r);
        sensor1_r <= decode_temp(in_byte1, temp_ofs_r);
      end else if (in_frame_index == FRAME_STATUS) begin
        fault_r   <= {in_byte3, in_byte2, in_byte1, in_byte0};
        balance_r <= {in_byte5, in_byte4};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      query_r <= in_query_cell;
    end
  end

  assign req.upd   = in_acc && (in_kind == KIND_CELL);
  assign req.wr_ok = (in_frame_index != FRAME_STATUS)
                     && (in_frame_index <= FRAME_LAST_CELL)
                     && (balance_r == 16'd0) && !in_ignition;
  assign req.frame = in_frame_index;
  assign req.v0    = {in_byte1[5:0], in_byte0};
  assign req.v1    = {in_byte3[5:0], in_byte2};
  assign req.v2    = {in_byte5[5:0], in_byte4};

  // Cell lanes.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_lane
    bcfm_lane #(
      .LANE_IDX (i)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .req        (req),
      .ignore_mv  (ignore_r),
      .cell_mv    (lane_mv[i]),
      .lowest_mv  (lane_lowest[i]),
      .highest_mv (lane_highest[i]),
      .term       (terms[i])
    );
  end

  bcfm_merge #(
    .NUM_CELLS (NUM_CELLS)
  ) u_merge (
    .clk   (clk),
    .load  (part_load),
    .terms (terms),
    .stats (stats)
  );

  // Queried cell and temperature extremes.
  always_comb begin
    q_mv      = '0;
    q_lowest  = '0;
    q_highest = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (query_r == QIDX_W'(i)) begin
        q_mv      = lane_mv[i];
        q_lowest  = lane_lowest[i];
        q_highest = lane_highest[i];
      end
    end
  end

  assign t_low  = (sensor0_r < sensor1_r) ? sensor0_r : sensor1_r;
  assign t_high = (sensor0_r > sensor1_r) ? sensor0_r : sensor1_r;

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_low_cell_mv      <= stats.low_mv;
      out_high_cell_mv     <= stats.high_mv;
      out_sum_mv           <= stats.sum_mv;
      out_valid_count      <= stats.count;
      out_balance_status   <= balance_r;
      out_error_word       <= fault_r;
      out_low_temp_c       <= t_low;
      out_high_temp_c      <= t_high;
      out_query_mv         <= q_mv;
      out_query_lowest_mv  <= q_lowest;
      out_query_highest_mv <= q_highest;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
